// ===== rtl/k_group_stream_reverser_assert.svh =====
// ----------------------------------------------------------------------------
// k_group_stream_reverser_assert.svh
// Assertion macros used by the checker file of the stream reverser.
// ----------------------------------------------------------------------------
`ifndef K_GROUP_STREAM_REVERSER_ASSERT_SVH
`define K_GROUP_STREAM_REVERSER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define KGSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define KGSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/kgsr_pkg.sv =====
// ----------------------------------------------------------------------------
// kgsr_pkg
// Shared constants and types of the k-group stream reverser.
// ----------------------------------------------------------------------------
`default_nettype none

package kgsr_pkg;

  localparam int unsigned MAX_GROUP_DEF = 16;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned GSIZE_W       = 5;

  localparam logic [GSIZE_W-1:0] GSIZE_RESET = 5'd1;

  // depth of the output queue behind the buffer read port
  localparam logic [1:0] Q_DEPTH = 2'd2;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  // read request tags, carried alongside the buffer read
  typedef struct packed {
    logic en;
    logic run_end;
    logic list_done;
  } rd_tag_t;

  // registered read response control
  typedef struct packed {
    logic valid;
    logic run_end;
    logic list_done;
  } rd_resp_t;

  // output queue status seen by the controller
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/k_group_stream_reverser.sv =====
// ----------------------------------------------------------------------------
// k_group_stream_reverser
// Reverses a value stream in groups of group_size; a short tail keeps order.
// ----------------------------------------------------------------------------
// Values arrive one item per cycle and are written into a single group
// buffer memory. The item that fills the group (or carries list_end) closes
// it: input then stalls while the group is read back, one entry per cycle
// while the output queue has room, through the buffer's single read port,
// reversed for a full group and in arrival order for a short tail at the
// end of a list. Results leave through a two-entry queue, so input reopens
// as soon as the last read is issued, while the tail of the group is still
// being delivered.
// Write group_size only while no results are owed; a write between items of
// a partly filled group applies from the next item on, and the group closes
// at the first arrival that brings the held count to or past the new size.
// Zero acts as one and values above MAX_GROUP saturate to MAX_GROUP.
// out_run_end marks the last result caused by one input item, out_list_done
// the final result of a list.
// ----------------------------------------------------------------------------
`default_nettype none

module k_group_stream_reverser #(
  parameter int unsigned MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input items
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [kgsr_pkg::VALUE_W-1:0] in_value,
  input  wire logic                         in_list_end,
  // result items
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [kgsr_pkg::VALUE_W-1:0] out_value,
  output logic                              out_run_end,
  output logic                              out_list_done,
  // group size register
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [kgsr_pkg::GSIZE_W-1:0] cfg_group_size
);

  localparam int unsigned AW = $clog2(MAX_GROUP);

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                rd_addr;
  kgsr_pkg::rd_tag_t            rd_tag;
  kgsr_pkg::rd_resp_t           rd_resp;
  logic [kgsr_pkg::VALUE_W-1:0] rd_data;
  logic [kgsr_pkg::VALUE_W-1:0] q_value;
  kgsr_pkg::q_stat_t            q_stat;

  // sequence fill and drain, own the group size register
  kgsr_ctrl #(
    .MAX_GROUP (MAX_GROUP)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_list_end    (in_list_end),
    .in_stall       (in_stall),
    .cfg_valid      (cfg_valid),
    .cfg_group_size (cfg_group_size),
    .cfg_ready      (cfg_ready),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .rd_addr        (rd_addr),
    .rd_tag         (rd_tag),
    .rd_resp        (rd_resp),
    .q_stat         (q_stat)
  );

  // hold the current group
  kgsr_buf #(
    .MAX_GROUP (MAX_GROUP)
  ) u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_addr (rd_addr),
    .rd_tag  (rd_tag),
    .rd_data (rd_data),
    .rd_resp (rd_resp)
  );

  // decouple the read latency from the sink's stall
  kgsr_outq u_outq (
    .clk           (clk),
    .rst_n         (rst_n),
    .push_data     (rd_data),
    .push_resp     (rd_resp),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_value     (q_value),
    .out_run_end   (out_run_end),
    .out_list_done (out_list_done),
    .q_stat        (q_stat)
  );

  assign out_value = q_value;

endmodule

`default_nettype wire

// ===== rtl/kgsr_buf.sv =====
// ----------------------------------------------------------------------------
// kgsr_buf
// Group buffer memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module kgsr_buf #(
  parameter int unsigned MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF,
  localparam int unsigned AW = $clog2(MAX_GROUP)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [AW-1:0]                  wr_addr,
  input  wire logic [kgsr_pkg::VALUE_W-1:0]   wr_data,
  input  wire logic [AW-1:0]                  rd_addr,
  input  wire kgsr_pkg::rd_tag_t              rd_tag,
  output logic      [kgsr_pkg::VALUE_W-1:0]   rd_data,
  output kgsr_pkg::rd_resp_t                  rd_resp
);

  logic [kgsr_pkg::VALUE_W-1:0] mem [MAX_GROUP];
  logic [kgsr_pkg::VALUE_W-1:0] rd_data_r;
  logic                         rd_valid_r;
  logic                         rd_run_end_r;
  logic                         rd_list_done_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_tag.en) begin
      rd_data_r      <= mem[rd_addr];
      rd_run_end_r   <= rd_tag.run_end;
      rd_list_done_r <= rd_tag.list_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_tag.en;
    end
  end

  assign rd_data           = rd_data_r;
  assign rd_resp.valid     = rd_valid_r;
  assign rd_resp.run_end   = rd_run_end_r;
  assign rd_resp.list_done = rd_list_done_r;

endmodule

`default_nettype wire

// ===== rtl/kgsr_outq.sv =====
// ----------------------------------------------------------------------------
// kgsr_outq
// Two-entry output queue; absorbs the read in flight while the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module kgsr_outq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [kgsr_pkg::VALUE_W-1:0] push_data,
  input  wire kgsr_pkg::rd_resp_t           push_resp,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic      [kgsr_pkg::VALUE_W-1:0] out_value,
  output logic                              out_run_end,
  output logic                              out_list_done,
  output kgsr_pkg::q_stat_t                 q_stat
);

  logic [kgsr_pkg::VALUE_W-1:0] val_r [2];
  logic                         re_r  [2];
  logic                         ld_r  [2];
  logic                         wptr_r, wptr_nxt;
  logic                         rptr_r, rptr_nxt;
  logic [1:0]                   cnt_r, cnt_nxt;
  logic                         push;
  logic                         pop;

  assign push = push_resp.valid;
  assign pop  = (cnt_r != 2'd0) && !out_stall;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop  ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      val_r[wptr_r] <= push_data;
      re_r[wptr_r]  <= push_resp.run_end;
      ld_r[wptr_r]  <= push_resp.list_done;
    end
  end

  assign out_valid     = (cnt_r != 2'd0);
  assign out_value     = val_r[rptr_r];
  assign out_run_end   = re_r[rptr_r];
  assign out_list_done = ld_r[rptr_r];
  assign q_stat.count  = cnt_r;
  assign q_stat.pop    = pop;

endmodule

`default_nettype wire

// ===== rtl/kgsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// kgsr_ctrl
// Fill/drain sequencer: writes arriving values, then reads the group back.
// ----------------------------------------------------------------------------
`default_nettype none

module kgsr_ctrl #(
  parameter int unsigned MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF,
  localparam int unsigned AW = $clog2(MAX_GROUP),
  localparam int unsigned CW = $clog2(MAX_GROUP + 1),
  localparam int unsigned KW = (CW > kgsr_pkg::GSIZE_W) ? CW : kgsr_pkg::GSIZE_W
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_list_end,
  output logic                              in_stall,
  input  wire logic                         cfg_valid,
  input  wire logic [kgsr_pkg::GSIZE_W-1:0] cfg_group_size,
  output logic                              cfg_ready,
  output logic                              wr_en,
  output logic      [AW-1:0]                wr_addr,
  output logic      [AW-1:0]                rd_addr,
  output kgsr_pkg::rd_tag_t                 rd_tag,
  input  wire kgsr_pkg::rd_resp_t           rd_resp,
  input  wire kgsr_pkg::q_stat_t            q_stat
);

  kgsr_pkg::state_t             state_r, state_nxt;
  logic [CW-1:0]                fill_r, fill_nxt;
  logic [CW-1:0]                rem_r, rem_nxt;
  logic [AW-1:0]                idx_r, idx_nxt;
  logic                         rev_r, rev_nxt;
  logic                         last_r, last_nxt;
  logic [kgsr_pkg::GSIZE_W-1:0] gsize_r, gsize_nxt;

  logic [KW-1:0] gs_ext;
  logic [KW-1:0] k_eff;
  logic [CW-1:0] n_cnt;
  logic          in_acc;
  logic          close;
  logic [2:0]    occ;
  logic          issue;
  logic          rem_one;

  // effective group size: zero acts as one, saturate at the buffer depth
  always_comb begin
    gs_ext = KW'(gsize_r);
    if (gs_ext == '0) begin
      k_eff = KW'(1);
    end else if (gs_ext > KW'(MAX_GROUP)) begin
      k_eff = KW'(MAX_GROUP);
    end else begin
      k_eff = gs_ext;
    end
  end

  assign in_acc  = in_valid && (state_r == kgsr_pkg::ST_FILL);
  assign n_cnt   = fill_r + CW'(1);
  assign close   = (KW'(n_cnt) >= k_eff);
  assign rem_one = (rem_r == CW'(1));

  // issue a read only when the queue has room for it once it lands
  assign occ   = {1'b0, q_stat.count} + {2'b00, rd_resp.valid};
  assign issue = (state_r == kgsr_pkg::ST_DRAIN) &&
                 (occ < ({1'b0, kgsr_pkg::Q_DEPTH} + {2'b00, q_stat.pop}));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kgsr_pkg::ST_FILL: begin
        if (in_acc && (close || in_list_end)) begin
          state_nxt = kgsr_pkg::ST_DRAIN;
        end
      end
      kgsr_pkg::ST_DRAIN: begin
        if (issue && rem_one) begin
          state_nxt = kgsr_pkg::ST_FILL;
        end
      end
      default: begin
        state_nxt = kgsr_pkg::ST_FILL;
      end
    endcase
  end

  // counters and pointers
  always_comb begin
    fill_nxt  = fill_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    rev_nxt   = rev_r;
    last_nxt  = last_r;
    gsize_nxt = gsize_r;
    if (cfg_valid && cfg_ready) begin
      gsize_nxt = cfg_group_size;
    end
    if (in_acc) begin
      if (close || in_list_end) begin
        fill_nxt = '0;
        rem_nxt  = n_cnt;
        rev_nxt  = close;
        last_nxt = in_list_end;
        idx_nxt  = close ? fill_r[AW-1:0] : '0;
      end else begin
        fill_nxt = n_cnt;
      end
    end
    if (issue) begin
      rem_nxt = rem_r - CW'(1);
      idx_nxt = rev_r ? (idx_r - AW'(1)) : (idx_r + AW'(1));
    end
  end

  // outputs
  always_comb begin
    in_stall         = (state_r != kgsr_pkg::ST_FILL);
    cfg_ready        = 1'b1;
    wr_en            = in_acc;
    wr_addr          = fill_r[AW-1:0];
    rd_addr          = idx_r;
    rd_tag.en        = issue;
    rd_tag.run_end   = rem_one;
    rd_tag.list_done = rem_one && last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kgsr_pkg::ST_FILL;
      fill_r  <= '0;
      rem_r   <= '0;
      gsize_r <= kgsr_pkg::GSIZE_RESET;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      rem_r   <= rem_nxt;
      gsize_r <= gsize_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    rev_r  <= rev_nxt;
    last_r <= last_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/kgsr_checker.sv =====
// ----------------------------------------------------------------------------
// kgsr_port_checker
// Port-level checks of the stream reverser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "k_group_stream_reverser_assert.svh"

module kgsr_port_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [kgsr_pkg::VALUE_W-1:0] out_value,
  input wire logic                         out_run_end,
  input wire logic                         out_list_done
);

  // a list can only end on the last result of an item
  `KGSR_ASSERT(a_done_run_end, out_valid && out_list_done |-> out_run_end, "list_done alone")

  // reset empties the result side
  `KGSR_ASSERT_ALWAYS(a_reset_no_out, !rst_n |=> !out_valid, "out_valid after reset")

  // reset leaves the block ready to fill
  `KGSR_ASSERT_ALWAYS(a_reset_accepts, !rst_n |=> !in_stall, "in_stall after reset")

  // a stalled result holds
  `KGSR_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_value), "result moved")

endmodule

bind k_group_stream_reverser kgsr_port_checker u_kgsr_port_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value     (out_value),
  .out_run_end   (out_run_end),
  .out_list_done (out_list_done)
);

`default_nettype wire
